[rtl/lsc_pkg.sv]
package lsc_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WINDOW_LEFT   = 2'd0,
      CSR_WINDOW_RIGHT  = 2'd1,
      CSR_WINDOW_BOTTOM = 2'd2,
      CSR_WINDOW_TOP    = 2'd3
   } csr_index_type;

   // Outcode bits
   typedef logic [3:0] outcode_type;

   localparam outcode_type CODE_TOP    = 4'b1000;
   localparam outcode_type CODE_BOTTOM = 4'b0100;
   localparam outcode_type CODE_RIGHT  = 4'b0010;
   localparam outcode_type CODE_LEFT   = 4'b0001;
   localparam outcode_type CODE_INSIDE = 4'b0000;

   // Endpoint moves allowed before the segment is dropped
   localparam int PASS_WIDTH = 3;
   localparam logic [PASS_WIDTH-1:0] MAX_PASSES = 3'd4;

   // Clipper sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CODE = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Multiply-divide unit states
   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

endpackage

[rtl/lsc_channels.sv]
// Segment request channel
interface lsc_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// Clipped segment response channel
interface lsc_rsp_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          visible;
   logic signed [COORD_WIDTH-1:0] clipped_start_x;
   logic signed [COORD_WIDTH-1:0] clipped_start_y;
   logic signed [COORD_WIDTH-1:0] clipped_end_x;
   logic signed [COORD_WIDTH-1:0] clipped_end_y;

   modport source (output valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, input ready);
   modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, output ready);
endinterface

[rtl/lsc_window_regs.sv]
module lsc_window_regs #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  lsc_pkg::csr_index_type        csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata,
   output logic signed [COORD_WIDTH-1:0] window_left,
   output logic signed [COORD_WIDTH-1:0] window_right,
   output logic signed [COORD_WIDTH-1:0] window_bottom,
   output logic signed [COORD_WIDTH-1:0] window_top
);
   import lsc_pkg::*;

   logic signed [COORD_WIDTH-1:0] left_ff, left_in;
   logic signed [COORD_WIDTH-1:0] right_ff, right_in;
   logic signed [COORD_WIDTH-1:0] bottom_ff, bottom_in;
   logic signed [COORD_WIDTH-1:0] top_ff, top_in;

   // Write decode
   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      top_in    = top_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   left_in   = signed'(csr_wdata);
            CSR_WINDOW_RIGHT:  right_in  = signed'(csr_wdata);
            CSR_WINDOW_BOTTOM: bottom_in = signed'(csr_wdata);
            CSR_WINDOW_TOP:    top_in    = signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
         top_ff    <= '0;
      end else begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
   end

   assign window_left   = left_ff;
   assign window_right  = right_ff;
   assign window_bottom = bottom_ff;
   assign window_top    = top_ff;

endmodule

[rtl/lsc_mul_div.sv]
// floor(a * b / d): a multiply step, then one quotient bit per cycle.
// Requires the high half of a * b to be below d; d of zero gives 0.
module lsc_mul_div #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COORD_WIDTH-1:0] mag_a,
   input  logic [COORD_WIDTH-1:0] mag_b,
   input  logic [COORD_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [COORD_WIDTH-1:0] quotient
);
   import lsc_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int CW = $clog2(W);

   md_state_type    state_ff, state_in;
   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W-1:0]    d_ff, d_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    low_ff, low_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            zero_ff, zero_in;
   logic            done_ff, done_in;

   logic [2*W-1:0]  product;
   logic [W:0]      trial;
   logic [W+1:0]    diff;

   assign product = a_ff * b_ff;
   assign trial   = {rem_ff, low_ff[W-1]};
   assign diff    = {1'b0, trial} - {2'b00, d_ff};

   // Sequencing of multiply and restoring division
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      count_in = count_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               a_in     = mag_a;
               b_in     = mag_b;
               d_in     = divisor;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            rem_in   = product[2*W-1:W];
            low_in   = product[W-1:0];
            count_in = '0;
            zero_in  = (d_ff == '0);
            state_in = MD_DIV;
         end
         MD_DIV: begin
            // subtract succeeds when no borrow
            if (!diff[W+1]) begin
               rem_in = diff[W-1:0];
               low_in = {low_ff[W-2:0], 1'b1};
            end else begin
               rem_in = trial[W-1:0];
               low_in = {low_ff[W-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == CW'(W-1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      count_ff <= count_in;
      zero_ff  <= zero_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : low_ff;

endmodule

[rtl/line_segment_clipper_unit.sv]
// Channel  Dir  Handshake     Payload
// req_if   in   valid/ready   start_x, start_y, end_x, end_y
// rsp_if   out  valid/ready   visible, clipped_start_x/y, clipped_end_x/y
// csr_*    in   write enable  csr_index selects window_left/right/bottom/top
//
// One segment at a time: accept, one outcode check per pass, load of the output
// register, and each endpoint move in the shared multiply-divide unit; up to
// four moves per segment.
// Synchronous active-high reset clears the window and control state.
// req_if.ready is high only while idle; a finished result waits in the
// output register, and the next segment may be taken meanwhile.
module line_segment_clipper_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   lsc_req_if.sink                    req_if,
   lsc_rsp_if.source                  rsp_if,
   input  logic                       csr_write_en,
   input  lsc_pkg::csr_index_type     csr_index,
   input  logic [COORD_WIDTH-1:0]     csr_wdata
);
   import lsc_pkg::*;

   localparam int W = COORD_WIDTH;

   logic signed [W-1:0] win_left, win_right, win_bottom, win_top;

   state_type               state_ff, state_in;
   logic signed [W-1:0]     x0_ff, x0_in, y0_ff, y0_in;
   logic signed [W-1:0]     x1_ff, x1_in, y1_ff, y1_in;
   logic [PASS_WIDTH-1:0]   pass_ff, pass_in;
   logic signed [W-1:0]     base_ff, base_in;
   logic signed [W-1:0]     edge_val_ff, edge_val_in;
   logic                    neg_ff, neg_in;
   logic                    y_edge_ff, y_edge_in;
   logic                    move_end_ff, move_end_in;
   logic                    visible_ff, visible_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_visible_ff, rsp_visible_in;
   logic signed [W-1:0]     rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;
   logic signed [W-1:0]     rsp_ex_ff, rsp_ex_in, rsp_ey_ff, rsp_ey_in;

   outcode_type             c0, c1, csel;
   logic                    sel_y_edge;
   logic signed [W-1:0]     sel_edge, sel_base, sel_num_ref;
   logic signed [W:0]       dx, dy, d_val, num_val, den_val;
   logic [W-1:0]            mag_d, mag_num, mag_den;
   logic                    md_start, md_done;
   logic [W-1:0]            md_q;
   logic signed [W:0]       q_signed, new_coord;
   logic                    rsp_free;

   lsc_window_regs #(.COORD_WIDTH(W)) u_window_regs (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .window_left   (win_left),
      .window_right  (win_right),
      .window_bottom (win_bottom),
      .window_top    (win_top)
   );

   lsc_mul_div #(.COORD_WIDTH(W)) u_mul_div (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mag_a    (mag_d),
      .mag_b    (mag_num),
      .divisor  (mag_den),
      .done     (md_done),
      .quotient (md_q)
   );

   function automatic outcode_type outcode(input logic signed [W-1:0] x,
                                           input logic signed [W-1:0] y,
                                           input logic signed [W-1:0] wl,
                                           input logic signed [W-1:0] wr,
                                           input logic signed [W-1:0] wb,
                                           input logic signed [W-1:0] wt);
      outcode_type c;
      c = CODE_INSIDE;
      if (y > wt) c = c | CODE_TOP;
      if (y < wb) c = c | CODE_BOTTOM;
      if (x > wr) c = c | CODE_RIGHT;
      if (x < wl) c = c | CODE_LEFT;
      return c;
   endfunction

   function automatic logic [W-1:0] magnitude(input logic signed [W:0] v);
      logic [W:0] n;
      n = -v;
      return v[W] ? n[W-1:0] : v[W-1:0];
   endfunction

   // Outcodes and edge selection for the current endpoints
   always_comb begin
      c0   = outcode(x0_ff, y0_ff, win_left, win_right, win_bottom, win_top);
      c1   = outcode(x1_ff, y1_ff, win_left, win_right, win_bottom, win_top);
      csel = (c0 != CODE_INSIDE) ? c0 : c1;
      sel_y_edge = ((csel & (CODE_TOP | CODE_BOTTOM)) != CODE_INSIDE);
      if ((csel & CODE_TOP) != CODE_INSIDE)         sel_edge = win_top;
      else if ((csel & CODE_BOTTOM) != CODE_INSIDE) sel_edge = win_bottom;
      else if ((csel & CODE_RIGHT) != CODE_INSIDE)  sel_edge = win_right;
      else                                          sel_edge = win_left;
   end

   // Operands of the intersection p0 + d * num / den
   always_comb begin
      dx = {x1_ff[W-1], x1_ff} - {x0_ff[W-1], x0_ff};
      dy = {y1_ff[W-1], y1_ff} - {y0_ff[W-1], y0_ff};
      sel_base    = sel_y_edge ? x0_ff : y0_ff;
      sel_num_ref = sel_y_edge ? y0_ff : x0_ff;
      d_val   = sel_y_edge ? dx : dy;
      den_val = sel_y_edge ? dy : dx;
      num_val = {sel_edge[W-1], sel_edge} - {sel_num_ref[W-1], sel_num_ref};
      mag_d   = magnitude(d_val);
      mag_num = magnitude(num_val);
      mag_den = magnitude(den_val);
   end

   // Moved coordinate from the quotient
   always_comb begin
      q_signed  = neg_ff ? -signed'({1'b0, md_q}) : signed'({1'b0, md_q});
      new_coord = {base_ff[W-1], base_ff} + q_signed;
   end

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      pass_in     = pass_ff;
      base_in     = base_ff;
      edge_val_in = edge_val_ff;
      neg_in      = neg_ff;
      y_edge_in   = y_edge_ff;
      move_end_in = move_end_ff;
      visible_in  = visible_ff;
      md_start    = 1'b0;

      rsp_valid_in   = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_sx_in      = rsp_sx_ff;
      rsp_sy_in      = rsp_sy_ff;
      rsp_ex_in      = rsp_ex_ff;
      rsp_ey_in      = rsp_ey_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               x0_in    = req_if.start_x;
               y0_in    = req_if.start_y;
               x1_in    = req_if.end_x;
               y1_in    = req_if.end_y;
               pass_in  = '0;
               state_in = ST_CODE;
            end
         end
         ST_CODE: begin
            if ((c0 | c1) == CODE_INSIDE) begin
               visible_in = 1'b1;
               state_in   = ST_DONE;
            end else if ((c0 & c1) != CODE_INSIDE || pass_ff == MAX_PASSES) begin
               visible_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               md_start    = 1'b1;
               base_in     = sel_base;
               edge_val_in = sel_edge;
               y_edge_in   = sel_y_edge;
               neg_in      = d_val[W] ^ num_val[W] ^ den_val[W];
               move_end_in = (c0 == CODE_INSIDE);
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (md_done) begin
               if (move_end_ff) begin
                  x1_in = y_edge_ff ? new_coord[W-1:0] : edge_val_ff;
                  y1_in = y_edge_ff ? edge_val_ff : new_coord[W-1:0];
               end else begin
                  x0_in = y_edge_ff ? new_coord[W-1:0] : edge_val_ff;
                  y0_in = y_edge_ff ? edge_val_ff : new_coord[W-1:0];
               end
               pass_in  = pass_ff + 1'b1;
               state_in = ST_CODE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = visible_ff;
               rsp_sx_in      = visible_ff ? x0_ff : '0;
               rsp_sy_in      = visible_ff ? y0_ff : '0;
               rsp_ex_in      = visible_ff ? x1_ff : '0;
               rsp_ey_in      = visible_ff ? y1_ff : '0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff          <= x0_in;
      y0_ff          <= y0_in;
      x1_ff          <= x1_in;
      y1_ff          <= y1_in;
      base_ff        <= base_in;
      edge_val_ff    <= edge_val_in;
      neg_ff         <= neg_in;
      y_edge_ff      <= y_edge_in;
      move_end_ff    <= move_end_in;
      visible_ff     <= visible_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_sx_ff      <= rsp_sx_in;
      rsp_sy_ff      <= rsp_sy_in;
      rsp_ex_ff      <= rsp_ex_in;
      rsp_ey_ff      <= rsp_ey_in;
   end

   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.visible         = rsp_visible_ff;
   assign rsp_if.clipped_start_x = rsp_sx_ff;
   assign rsp_if.clipped_start_y = rsp_sy_ff;
   assign rsp_if.clipped_end_x   = rsp_ex_ff;
   assign rsp_if.clipped_end_y   = rsp_ey_ff;

endmodule
